// ----- hw/rtl/plf_pkg.sv -----
// Package for the line-following PID block: widths, reset values,
// register indexes and the beat and stage structs.
// Depends on nothing; every other file of the block imports it.
package plf_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int OFFSET_W    = 10;
    localparam int GAIN_W      = 16;
    localparam int BASE_W      = 11;
    localparam int POS_W       = 32;
    localparam int DRIVE_W     = 12;
    localparam int INTEG_W     = 24;
    localparam int FRAC_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int ERR_W  = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
    localparam int ACC_W  = ((INTEG_W + 3 > ERR_W + FRAC_W) ? INTEG_W + 3 : ERR_W + FRAC_W) + 1;
    localparam int PP_W   = ERR_W + GAIN_W + 1;
    localparam int PI_W   = INTEG_W + GAIN_W + 1;
    localparam int PD_W   = ERR_W + GAIN_W + 2;
    localparam int SUM_W  = ((PD_W + FRAC_W > PI_W) ? PD_W + FRAC_W : PI_W) + 2;
    localparam int TURN_W = SUM_W - 2 * FRAC_W;
    localparam int DRV_X_W = TURN_W + 2;

    localparam int DRIVE_LIMIT = 1500;

    localparam logic [GAIN_W-1:0]   GAIN_P_RST        = 16'd819;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST        = 16'd26;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST        = 16'd2099;
    localparam logic [OFFSET_W-1:0] LINE_OFFSET_RST   = 10'd880;
    localparam logic [BASE_W-1:0]   BASE_SPEED_RST    = 11'd1100;
    localparam logic [POS_W-1:0]    STOP_DISTANCE_RST = 32'd5240;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE = 3'd5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]   sensor_sample;
        logic signed [POS_W-1:0]  motor_position;
        logic                     run_start;
    } t_in_item;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      run_done;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
        logic [OFFSET_W-1:0]      line_offset;
        logic [BASE_W-1:0]        base_speed;
        logic signed [POS_W-1:0]  stop_distance;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W:0]     deriv;
        logic                      run_done;
    } t_err_item;

    typedef struct packed {
        logic signed [PP_W-1:0] prod_p;
        logic signed [PI_W-1:0] prod_i;
        logic signed [PD_W-1:0] prod_d;
        logic                   run_done;
    } t_prod_item;

endpackage

// ----- hw/rtl/pid_line_follower.sv -----
// Top level of the line-following PID block: handshakes, input register,
// stage valid bits and the three datapath stages.
// Depends on plf_pkg, plf_cfg_regs, plf_error_stage, plf_mult_stage, plf_drive_stage.
//
// Usage:
// Each input beat on i_in_valid/o_in_ready carries a sensor sample, a motor
// position and a run-start flag, and yields exactly one output beat on
// o_out_valid/i_out_ready with the left and right drive and the done flag.
// Results leave in the order the samples arrived.
// A beat passes the input register, the error and integral stage, the product
// stage and the result register before o_out_valid rises. Throughput is one
// beat per cycle while the receiver does not stall; the integral and previous-error
// feedback closes within the error stage, so consecutive samples need no spacing.
// When the receiver stalls, the four stages keep accepting until each holds
// a beat; o_in_ready then follows i_out_ready combinationally.
// Configuration beats on i_cfg_valid/o_cfg_ready are always accepted;
// indexes beyond the register list are ignored.
// Reset (synchronous, active low) empties the pipeline, clears the integral
// and previous error and restores the register defaults.
module pid_line_follower (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  plf_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output plf_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [plf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import plf_pkg::*;

    logic [3:0]  r_vld;
    logic [3:0]  n_vld;
    logic [3:0]  rdy;
    t_in_item    r_in;
    t_cfg        cfg;
    t_err_item   err_stage;
    t_prod_item  prod_stage;

    assign rdy[3] = !r_vld[3] || i_out_ready;
    assign rdy[2] = !r_vld[2] || rdy[3];
    assign rdy[1] = !r_vld[1] || rdy[2];
    assign rdy[0] = !r_vld[0] || rdy[1];

    assign n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
    assign n_vld[1] = rdy[1] ? r_vld[0]   : r_vld[1];
    assign n_vld[2] = rdy[2] ? r_vld[1]   : r_vld[2];
    assign n_vld[3] = rdy[3] ? r_vld[2]   : r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && rdy[0]) begin
            r_in <= i_in_data;
        end
    end

    plf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    plf_error_stage u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_vld[0] && rdy[1]),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_stage (err_stage)
    );

    plf_mult_stage u_mult (
        .i_clk   (i_clk),
        .i_load  (r_vld[1] && rdy[2]),
        .i_stage (err_stage),
        .i_cfg   (cfg),
        .o_stage (prod_stage)
    );

    plf_drive_stage u_drive (
        .i_clk   (i_clk),
        .i_load  (r_vld[2] && rdy[3]),
        .i_stage (prod_stage),
        .i_cfg   (cfg),
        .o_item  (o_out_data)
    );

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[3];
    assign o_cfg_ready = 1'b1;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == 4'b0000))
        else $error("pipeline not empty after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld && !i_out_ready))
        else $error("input stalled while a stage was free");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_data.left_drive) <= DRIVE_LIMIT
                         && $signed(o_out_data.left_drive) >= -DRIVE_LIMIT))
        else $error("left drive outside its limit");

    a_right_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_data.right_drive) <= DRIVE_LIMIT
                         && $signed(o_out_data.right_drive) >= -DRIVE_LIMIT))
        else $error("right drive outside its limit");

endmodule

// ----- hw/rtl/plf_cfg_regs.sv -----
// Configuration register file of the line-following PID block.
// Depends on plf_pkg for the register indexes, reset values and t_cfg.
module plf_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [plf_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0]  i_data,
    output plf_pkg::t_cfg                   o_cfg
);
    import plf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_GAIN_P:        n_cfg.gain_p        = i_data[GAIN_W-1:0];
                CFG_GAIN_I:        n_cfg.gain_i        = i_data[GAIN_W-1:0];
                CFG_GAIN_D:        n_cfg.gain_d        = i_data[GAIN_W-1:0];
                CFG_LINE_OFFSET:   n_cfg.line_offset   = i_data[OFFSET_W-1:0];
                CFG_BASE_SPEED:    n_cfg.base_speed    = i_data[BASE_W-1:0];
                CFG_STOP_DISTANCE: n_cfg.stop_distance = i_data[POS_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p        <= GAIN_P_RST;
            r_cfg.gain_i        <= GAIN_I_RST;
            r_cfg.gain_d        <= GAIN_D_RST;
            r_cfg.line_offset   <= LINE_OFFSET_RST;
            r_cfg.base_speed    <= BASE_SPEED_RST;
            r_cfg.stop_distance <= STOP_DISTANCE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/plf_error_stage.sv -----
// Error stage: error, leaky integral with saturation, derivative and the
// stop compare. Holds the integral and previous error. Depends on plf_pkg.
module plf_error_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  plf_pkg::t_in_item   i_item,
    input  plf_pkg::t_cfg       i_cfg,
    output plf_pkg::t_err_item  o_stage
);
    import plf_pkg::*;

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev;
    t_err_item                 r_stage;

    logic [ERR_W-1:0]          sample_x;
    logic [ERR_W-1:0]          offset_x;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ_base;
    logic signed [ERR_W-1:0]   prev_base;
    logic signed [ACC_W-1:0]   integ_x;
    logic signed [ACC_W-1:0]   seven_x;
    logic signed [ACC_W-1:0]   leak;
    logic signed [ACC_W-1:0]   err_scaled;
    logic signed [ACC_W-1:0]   integ_sum;
    logic                      integ_ovf;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [ERR_W:0]     deriv;
    logic                      done;

    assign sample_x   = {{(ERR_W-SAMPLE_BITS){1'b0}}, i_item.sensor_sample};
    assign offset_x   = {{(ERR_W-OFFSET_W){1'b0}}, i_cfg.line_offset};
    assign err        = $signed(sample_x - offset_x);
    assign integ_base = i_item.run_start ? '0 : r_integ;
    assign prev_base  = i_item.run_start ? '0 : r_prev;

    assign integ_x    = {{(ACC_W-INTEG_W){integ_base[INTEG_W-1]}}, integ_base};
    assign seven_x    = (integ_x <<< 3) - integ_x;
    assign leak       = seven_x >>> 3;
    assign err_scaled = {{(ACC_W-ERR_W-FRAC_W){err[ERR_W-1]}}, err, {FRAC_W{1'b0}}};
    assign integ_sum  = leak + err_scaled;
    assign integ_ovf  = !((&integ_sum[ACC_W-1:INTEG_W-1]) || !(|integ_sum[ACC_W-1:INTEG_W-1]));

    always_comb begin
        if (integ_ovf) begin
            n_integ = integ_sum[ACC_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
    end

    assign deriv = {err[ERR_W-1], err} - {prev_base[ERR_W-1], prev_base};
    assign done  = i_item.motor_position > i_cfg.stop_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_load) begin
            r_integ <= n_integ;
            r_prev  <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage.err      <= err;
            r_stage.integ    <= n_integ;
            r_stage.deriv    <= deriv;
            r_stage.run_done <= done;
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- hw/rtl/plf_mult_stage.sv -----
// Product stage: the three gain products of the PID terms, registered.
// Depends on plf_pkg for t_err_item, t_prod_item and t_cfg.
module plf_mult_stage (
    input  logic                i_clk,
    input  logic                i_load,
    input  plf_pkg::t_err_item  i_stage,
    input  plf_pkg::t_cfg       i_cfg,
    output plf_pkg::t_prod_item o_stage
);
    import plf_pkg::*;

    t_prod_item r_stage;

    logic signed [GAIN_W:0] gp_s;
    logic signed [GAIN_W:0] gi_s;
    logic signed [GAIN_W:0] gd_s;
    logic signed [PP_W-1:0] prod_p;
    logic signed [PI_W-1:0] prod_i;
    logic signed [PD_W-1:0] prod_d;

    assign gp_s   = {1'b0, i_cfg.gain_p};
    assign gi_s   = {1'b0, i_cfg.gain_i};
    assign gd_s   = {1'b0, i_cfg.gain_d};
    assign prod_p = gp_s * i_stage.err;
    assign prod_i = gi_s * i_stage.integ;
    assign prod_d = gd_s * i_stage.deriv;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage.prod_p   <= prod_p;
            r_stage.prod_i   <= prod_i;
            r_stage.prod_d   <= prod_d;
            r_stage.run_done <= i_stage.run_done;
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- hw/rtl/plf_drive_stage.sv -----
// Drive stage: sum of the PID terms, truncation toward zero, the two
// saturated drive commands and the result register. Depends on plf_pkg.
module plf_drive_stage (
    input  logic                i_clk,
    input  logic                i_load,
    input  plf_pkg::t_prod_item i_stage,
    input  plf_pkg::t_cfg       i_cfg,
    output plf_pkg::t_out_item  o_item
);
    import plf_pkg::*;

    localparam logic signed [DRV_X_W-1:0] LIM_HI = DRV_X_W'(DRIVE_LIMIT);
    localparam logic signed [DRV_X_W-1:0] LIM_LO = -LIM_HI;

    t_out_item r_item;

    logic signed [SUM_W-1:0]   ext_p;
    logic signed [SUM_W-1:0]   ext_i;
    logic signed [SUM_W-1:0]   ext_d;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   sum_biased;
    logic signed [TURN_W-1:0]  turn;
    logic signed [DRV_X_W-1:0] turn_x;
    logic signed [DRV_X_W-1:0] base_x;
    logic signed [DRV_X_W-1:0] left_x;
    logic signed [DRV_X_W-1:0] right_x;
    logic signed [DRV_X_W-1:0] left_c;
    logic signed [DRV_X_W-1:0] right_c;

    assign ext_p = {{(SUM_W-PP_W-FRAC_W){i_stage.prod_p[PP_W-1]}}, i_stage.prod_p,
                    {FRAC_W{1'b0}}};
    assign ext_i = {{(SUM_W-PI_W){i_stage.prod_i[PI_W-1]}}, i_stage.prod_i};
    assign ext_d = {{(SUM_W-PD_W-FRAC_W){i_stage.prod_d[PD_W-1]}}, i_stage.prod_d,
                    {FRAC_W{1'b0}}};
    assign sum   = ext_p + ext_i + ext_d;

    // A negative sum gets a bias of one unit less than the divisor so that the
    // arithmetic shift truncates toward zero.
    assign sum_biased = sum + {{(SUM_W-2*FRAC_W){1'b0}}, {(2*FRAC_W){sum[SUM_W-1]}}};
    assign turn       = sum_biased[SUM_W-1:2*FRAC_W];

    assign turn_x  = {{2{turn[TURN_W-1]}}, turn};
    assign base_x  = {{(DRV_X_W-BASE_W){1'b0}}, i_cfg.base_speed};
    assign left_x  = base_x + turn_x;
    assign right_x = base_x - turn_x;

    always_comb begin
        if (left_x > LIM_HI) begin
            left_c = LIM_HI;
        end else if (left_x < LIM_LO) begin
            left_c = LIM_LO;
        end else begin
            left_c = left_x;
        end
        if (right_x > LIM_HI) begin
            right_c = LIM_HI;
        end else if (right_x < LIM_LO) begin
            right_c = LIM_LO;
        end else begin
            right_c = right_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.left_drive  <= left_c[DRIVE_W-1:0];
            r_item.right_drive <= right_c[DRIVE_W-1:0];
            r_item.run_done    <= i_stage.run_done;
        end
    end

    assign o_item = r_item;

endmodule

// ----- verif/pid_line_follower_tb.sv -----
// Self-checking testbench for pid_line_follower: random-stall sender, receiver
// and register writer, with a software copy of the PID steering law.
// Depends on plf_pkg and the pid_line_follower RTL only.
`timescale 1ns / 1ps

module pid_line_follower_tb;
    import plf_pkg::*;

    localparam int LATENCY      = 3;
    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 80;
    localparam int BLOCK_BEATS  = 125;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {SET_MIXED, SET_LOW, SET_HIGH} t_setting_kind;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies and feedback state of the steering law.
    logic [GAIN_W-1:0]        kp = GAIN_P_RST;
    logic [GAIN_W-1:0]        ki = GAIN_I_RST;
    logic [GAIN_W-1:0]        kd = GAIN_D_RST;
    logic [OFFSET_W-1:0]      line_mid = LINE_OFFSET_RST;
    logic [BASE_W-1:0]        base_speed = BASE_SPEED_RST;
    logic signed [POS_W-1:0]  stop_pos = STOP_DISTANCE_RST;
    logic signed [INTEG_W-1:0] integ_q8 = '0;
    logic signed [ERR_W-1:0]   last_err = '0;

    t_in_item   sample_q[$];
    t_out_item  drive_q[$];
    t_reg_write reg_write_q[$];

    int send_idle_pct = 26;
    int recv_idle_pct = 73;
    bit hold_armed = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    int fault_count = 0;
    int beats_sent = 0;
    int drives_checked = 0;
    int done_seen = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    pid_line_follower dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic t_out_item compute_drive(t_in_item beat);
        longint    err;
        longint    deriv;
        longint    acc;
        longint    sum;
        longint    turn;
        t_out_item res;
        if (beat.run_start) begin
            integ_q8 = '0;
            last_err = '0;
        end
        err = longint'(beat.sensor_sample) - longint'(line_mid);
        // Seven eighths of the old integral, floored, plus the new error in Q.8.
        acc = ((7 * longint'(integ_q8)) >>> 3) + err * 256;
        integ_q8 = INTEG_W'(clip(acc, -(longint'(1) <<< (INTEG_W - 1)),
                                 (longint'(1) <<< (INTEG_W - 1)) - 1));
        deriv = err - longint'(last_err);
        sum = longint'(kp) * err * 256 + longint'(ki) * longint'(integ_q8)
            + longint'(kd) * deriv * 256;
        turn = (sum >= 0) ? (sum >>> 16) : -((-sum) >>> 16);
        res.left_drive  = DRIVE_W'(clip(longint'(base_speed) + turn,
                                        -DRIVE_LIMIT, DRIVE_LIMIT));
        res.right_drive = DRIVE_W'(clip(longint'(base_speed) - turn,
                                        -DRIVE_LIMIT, DRIVE_LIMIT));
        res.run_done    = $signed(beat.motor_position) > $signed(stop_pos);
        last_err = ERR_W'(err);
        return res;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_P:        kp = data[GAIN_W-1:0];
            CFG_GAIN_I:        ki = data[GAIN_W-1:0];
            CFG_GAIN_D:        kd = data[GAIN_W-1:0];
            CFG_LINE_OFFSET:   line_mid = data[OFFSET_W-1:0];
            CFG_BASE_SPEED:    base_speed = data[BASE_W-1:0];
            CFG_STOP_DISTANCE: stop_pos = data[POS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void note_fault(string what, longint want, longint got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("Drive beat %0d, %s: expected %0d, actual %0d",
                     drives_checked, what, want, got);
        end
    endfunction

    // Sensor beat driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                drive_q.push_back(compute_drive(in_data));
                beats_sent++;
            end
            if (!in_valid || in_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    in_data  <= sample_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Register writer.
    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
                reg_writes++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_write_q.size() != 0) begin
                    cfg_index <= reg_write_q[0].idx;
                    cfg_data  <= reg_write_q[0].data;
                    cfg_valid <= 1'b1;
                    void'(reg_write_q.pop_front());
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Drive receiver, including one long hold-off to fill the pipeline.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Drive beat checker.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (drive_q.size() == 0) begin
                note_fault("beat with nothing expected", longint'(0),
                           longint'($signed(out_data.left_drive)));
            end else begin
                want = drive_q.pop_front();
                if (out_data.left_drive !== want.left_drive)
                    note_fault("left_drive", longint'($signed(want.left_drive)),
                               longint'($signed(out_data.left_drive)));
                if (out_data.right_drive !== want.right_drive)
                    note_fault("right_drive", longint'($signed(want.right_drive)),
                               longint'($signed(out_data.right_drive)));
                if (out_data.run_done !== want.run_done)
                    note_fault("run_done", longint'(want.run_done),
                               longint'(out_data.run_done));
                done_seen += int'(want.run_done);
            end
            drives_checked++;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d drive beats outstanding.",
                     cycle_count, drive_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_beat(input logic [SAMPLE_BITS-1:0] sample,
                             input logic [POS_W-1:0] pos, input logic start);
        t_in_item beat;
        beat.sensor_sample  = sample;
        beat.motor_position = pos;
        beat.run_start      = start;
        sample_q.push_back(beat);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        t_reg_write w;
        w.idx  = idx;
        w.data = data;
        reg_write_q.push_back(w);
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || in_valid || drive_q.size() != 0
               || reg_write_q.size() != 0 || cfg_valid)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(7, 0))
            0, 1:    return '0;
            2:       return '1;
            3:       return GAIN_W'($urandom());
            default: return GAIN_W'($urandom_range(4095, 0));
        endcase
    endfunction

    // Writes every register; bits above each register's width carry junk.
    task automatic write_settings(input t_setting_kind kind);
        logic [GAIN_W-1:0]   gp;
        logic [GAIN_W-1:0]   gi;
        logic [GAIN_W-1:0]   gd;
        logic [OFFSET_W-1:0] off;
        logic [BASE_W-1:0]   spd;
        logic [POS_W-1:0]    stop;
        case (kind)
            SET_LOW: begin
                gp = '0; gi = '0; gd = '0; off = '0; spd = '0;
                stop = 32'h8000_0000;
            end
            SET_HIGH: begin
                gp = '1; gi = '1; gd = '1; off = '1; spd = '1;
                stop = 32'h7FFF_FFFF;
            end
            default: begin
                gp   = pick_gain();
                gi   = pick_gain();
                gd   = pick_gain();
                off  = OFFSET_W'($urandom_range(1023, 0));
                spd  = BASE_W'($urandom_range(2047, 0));
                stop = ($urandom_range(2, 0) == 0) ? $urandom() : $urandom_range(20000, 0);
            end
        endcase
        push_write(CFG_GAIN_P, {16'($urandom()), gp});
        push_write(CFG_GAIN_I, {16'($urandom()), gi});
        push_write(CFG_GAIN_D, {16'($urandom()), gd});
        push_write(CFG_LINE_OFFSET, {22'($urandom()), off});
        push_write(CFG_BASE_SPEED, {21'($urandom()), spd});
        push_write(CFG_STOP_DISTANCE, stop);
        push_write(CFG_SPARE_LO, $urandom());
        push_write(CFG_SPARE_HI, $urandom());
        drain();
    endtask

    // Mostly runs: a start beat, then a wandering sample and a creeping position
    // that creeps toward and may cross the stop distance; the rest is unrelated noise.
    task automatic queue_random_beats(input int count);
        int k;
        int walk_sample;
        int walk_pos;
        bit start;
        walk_sample = int'(line_mid);
        walk_pos    = stop_pos;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(4, 0) == 0) begin
                push_beat(SAMPLE_BITS'($urandom()), $urandom(), 1'($urandom_range(1, 0)));
            end else begin
                start = (k == 0) || ($urandom_range(24, 0) == 0);
                if (start) begin
                    walk_sample = int'(line_mid) + int'($urandom_range(200, 0)) - 100;
                    walk_pos    = stop_pos - int'($urandom_range(400, 0));
                end
                walk_sample = int'(clip(longint'(walk_sample + int'($urandom_range(80, 0)) - 40),
                                        0, 1023));
                walk_pos    = walk_pos + int'($urandom_range(12, 0));
                push_beat(SAMPLE_BITS'(walk_sample), POS_W'(walk_pos), start);
            end
        end
    endtask

    initial begin
        t_setting_kind block_kind[6] = '{SET_MIXED, SET_LOW, SET_MIXED, SET_HIGH,
                                         SET_MIXED, SET_MIXED};
        int blk;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default registers: zero error, the sample extremes and the stop boundary.
        push_beat(10'd880, 32'd0, 1'b1);
        push_beat(10'd0, 32'd5240, 1'b0);
        push_beat(10'd1023, 32'd5241, 1'b0);
        push_beat(10'd1023, 32'h7FFF_FFFF, 1'b0);
        push_beat(10'd1023, 32'd100, 1'b0);
        push_beat(10'd0, 32'h8000_0000, 1'b0);
        push_beat(10'd0, 32'hFFFF_FFFF, 1'b0);
        push_beat(10'd1023, 32'd6000, 1'b1);
        push_beat(10'd440, 32'd6001, 1'b0);
        push_beat(10'd880, 32'd6002, 1'b0);
        push_beat(10'h155, 32'h5555_5555, 1'b0);
        push_beat(10'h2AA, 32'hAAAA_AAAA, 1'b0);
        drain();

        // Largest gains and a base speed beyond the drive limit.
        write_settings(SET_HIGH);
        push_beat(10'd0, 32'd0, 1'b1);
        push_beat(10'd1023, 32'hFFFF_FFFB, 1'b0);
        push_beat(10'd0, 32'h8000_0000, 1'b0);
        push_beat(10'd1023, 32'h7FFF_FFFF, 1'b0);
        push_beat(10'd1023, 32'd7, 1'b0);
        push_beat(10'd512, 32'd8, 1'b0);
        drain();

        // All registers at their lowest: the drives sit at zero.
        write_settings(SET_LOW);
        push_beat(10'd1023, 32'h8000_0000, 1'b1);
        push_beat(10'd0, 32'h8000_0001, 1'b0);
        push_beat(10'd1023, 32'd0, 1'b0);
        push_beat(10'd0, 32'h7FFF_FFFF, 1'b0);
        drain();

        for (blk = 0; blk < 6; blk++) begin
            write_settings(block_kind[blk]);
            if (blk >= 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (blk >= 2) begin
                send_idle_pct = 73;
                recv_idle_pct = 26;
            end
            queue_random_beats(BLOCK_BEATS);
            if (blk == 4)
                hold_armed = 1'b1;
            drain();
        end

        repeat (LATENCY + 4) @(negedge clk);
        $display("Sent %0d sensor beats and checked %0d drive beats, %0d past the stop.",
                 beats_sent, drives_checked, done_seen);
        $display("Applied %0d register writes over eight settings, with %0d mismatches.",
                 reg_writes, fault_count);
        if (fault_count == 0 && drive_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
